// File: rtl/core/drs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pkg
// Shared widths, register indexes, queue job type and helpers for the
// distance restraint score block.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int FIELD_W    = 20;
    localparam int TOL_W      = 16;
    localparam int SCORE_W    = 42;
    localparam int COORD_BITS = 20;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * COORD_BITS + 1;
    localparam int DSQ_W   = 2 * COORD_BITS + 2;
    localparam int ROOT_W  = COORD_BITS + 1;
    localparam int EX_W    = (ROOT_W > TOL_W) ? ROOT_W : TOL_W;
    localparam int RACC_W  = DSQ_W + 1;
    localparam int BIT_TOP = 2 * ((DSQ_W - 1) / 2);

    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_AW-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_AW-1:0] REG_CENTER_Z = 2'd2;
    localparam logic [CFG_AW-1:0] REG_TOLERANCE = 2'd3;

    localparam logic [SCORE_W-1:0] PENALTY = SCORE_W'(99 * 65536);

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic             penalty;
        logic [DSQ_W-1:0] dist_sq;
    } drs_job_t;

    function automatic logic signed [DIFF_W-1:0] sext_coord(input logic [FIELD_W-1:0] v);
        logic signed [COORD_BITS-1:0] t;
        t = v[COORD_BITS-1:0];
        return DIFF_W'(t);
    endfunction

endpackage

// File: rtl/core/drs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_front
// Accepts atom requests, computes squared distance to the center in two
// stages and folds it into the running minimum; queues a job at list end.
// ----------------------------------------------------------------------------
module drs_front
    import drs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_atom_x,
    input  logic [FIELD_W-1:0] s_atom_y,
    input  logic [FIELD_W-1:0] s_atom_z,
    input  logic               s_is_last,
    input  logic               s_empty_marker,
    input  logic [FIELD_W-1:0] center_x,
    input  logic [FIELD_W-1:0] center_y,
    input  logic [FIELD_W-1:0] center_z,
    output logic               q_push,
    output drs_job_t           q_push_job,
    input  logic               q_full
);

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic                     s1_empty_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg;
    logic signed [DIFF_W-1:0] s1_dy_reg;
    logic signed [DIFF_W-1:0] s1_dz_reg;

    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    logic                     s2_empty_reg;
    logic [SQ_W-1:0]          s2_sqx_reg;
    logic [SQ_W-1:0]          s2_sqy_reg;
    logic [SQ_W-1:0]          s2_sqz_reg;

    logic [DSQ_W-1:0]         min_reg;
    logic                     have_reg;

    logic                     advance;
    logic signed [2*DIFF_W-1:0] px;
    logic signed [2*DIFF_W-1:0] py;
    logic signed [2*DIFF_W-1:0] pz;
    logic [DSQ_W-1:0]         d2;
    logic [DSQ_W-1:0]         cand;

    assign advance = !(s2_valid_reg && (s2_last_reg || s2_empty_reg) && q_full);
    assign s_ready = advance;

    assign px = s1_dx_reg * s1_dx_reg;
    assign py = s1_dy_reg * s1_dy_reg;
    assign pz = s1_dz_reg * s1_dz_reg;

    assign d2 = DSQ_W'(s2_sqx_reg) + DSQ_W'(s2_sqy_reg) + DSQ_W'(s2_sqz_reg);
    assign cand = (have_reg && (min_reg <= d2)) ? min_reg : d2;

    assign q_push             = advance && s2_valid_reg && (s2_last_reg || s2_empty_reg);
    assign q_push_job.penalty = s2_empty_reg;
    assign q_push_job.dist_sq = cand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg) begin
                if (s2_empty_reg || s2_last_reg) begin
                    have_reg <= 1'b0;
                end else begin
                    have_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_last_reg  <= s_is_last;
            s1_empty_reg <= s_empty_marker;
            s1_dx_reg    <= sext_coord(s_atom_x) - sext_coord(center_x);
            s1_dy_reg    <= sext_coord(s_atom_y) - sext_coord(center_y);
            s1_dz_reg    <= sext_coord(s_atom_z) - sext_coord(center_z);
            s2_last_reg  <= s1_last_reg;
            s2_empty_reg <= s1_empty_reg;
            s2_sqx_reg   <= px[SQ_W-1:0];
            s2_sqy_reg   <= py[SQ_W-1:0];
            s2_sqz_reg   <= pz[SQ_W-1:0];
            if (s2_valid_reg && !s2_empty_reg && !s2_last_reg) begin
                min_reg <= cand;
            end
        end
    end

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

endmodule

// File: rtl/core/drs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_queue
// Short job queue between the distance front and the scoring back.
// ----------------------------------------------------------------------------
module drs_queue
    import drs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  drs_job_t push_job,
    output logic     full,
    input  logic     pop,
    output drs_job_t pop_job,
    output logic     empty
);

    drs_job_t         mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign full    = (count_reg == (QAW + 1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QAW + 1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

// File: rtl/core/drs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_back
// Takes queued jobs; a penalty job scores PENALTY, else a bit-pair square root
// over the minimum squared distance, flat-bottom tolerance and squared excess.
// ----------------------------------------------------------------------------
module drs_back
    import drs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TOL_W-1:0]   tolerance,
    input  logic               q_empty,
    input  drs_job_t           q_pop_job,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SCORE_W-1:0] m_score
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROOT   = 3'd1;
    localparam logic [2:0] ST_EXCESS = 3'd2;
    localparam logic [2:0] ST_SQUARE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [RACC_W-1:0] BIT_INIT = RACC_W'(1) << BIT_TOP;

    logic [2:0]          state_reg;
    logic [DSQ_W-1:0]    v_reg;
    logic [RACC_W-1:0]   root_reg;
    logic [RACC_W-1:0]   bit_reg;
    logic [ROOT_W-1:0]   ex_reg;
    logic [SCORE_W-1:0]  res_reg;
    logic                m_valid_reg;
    logic [SCORE_W-1:0]  m_score_reg;

    logic [RACC_W-1:0]   trial;
    logic                take;
    logic [EX_W-1:0]     dist_w;
    logic [EX_W-1:0]     tol_w;
    logic [EX_W-1:0]     diff_w;
    logic [2*ROOT_W-1:0] ex_sq;
    logic                out_free;

    assign trial    = root_reg + bit_reg;
    assign take     = (RACC_W'(v_reg) >= trial);
    assign dist_w   = EX_W'(root_reg[ROOT_W-1:0]);
    assign tol_w    = EX_W'(tolerance);
    assign diff_w   = dist_w - tol_w;
    assign ex_sq    = ex_reg * ex_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign m_valid  = m_valid_reg;
    assign m_score  = m_score_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        state_reg <= q_pop_job.penalty ? ST_DONE : ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (bit_reg[0]) begin
                        state_reg <= ST_EXCESS;
                    end
                end
                ST_EXCESS: state_reg <= ST_SQUARE;
                ST_SQUARE: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                v_reg    <= q_pop_job.dist_sq;
                root_reg <= '0;
                bit_reg  <= BIT_INIT;
                res_reg  <= PENALTY;
            end
            ST_ROOT: begin
                if (take) begin
                    v_reg    <= v_reg - trial[DSQ_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_EXCESS: begin
                ex_reg <= (dist_w > tol_w) ? diff_w[ROOT_W-1:0] : '0;
            end
            ST_SQUARE: begin
                res_reg <= SCORE_W'(ex_sq);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_score_reg <= res_reg;
                end
            end
            default: ;
        endcase
    end

    a_root_bit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT) |-> $onehot(bit_reg))
        else $error("root step bit not one-hot");

endmodule

// File: rtl/core/distance_restraint_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_restraint_score
// Flat-bottom harmonic restraint: minimum atom distance to a center, scored
// as the square of the excess over a tolerance at list end.
//
//   channel  ports                                   direction
//   s_       atom_x/y/z, is_last, empty_marker       request in
//   m_       score                                   request out
//   cfg_     wr_en, addr, wr_data                    register write
//
// Atom requests are taken one per cycle while s_ready is high; the front runs two stages deep.
// A list end in the back runs a 21-step square root, then excess, square and
// output load. A four-entry queue buffers list ends.
// Reset is synchronous, active low, and clears config registers and control; datapath registers are not reset.
// A stalled output backs up the queue, then the front, then s_ready.
// ----------------------------------------------------------------------------
module distance_restraint_score
    import drs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_atom_x,
    input  logic [FIELD_W-1:0] s_atom_y,
    input  logic [FIELD_W-1:0] s_atom_z,
    input  logic               s_is_last,
    input  logic               s_empty_marker,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SCORE_W-1:0] m_score,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [FIELD_W-1:0] cfg_wr_data
);

    logic [FIELD_W-1:0] center_x_reg;
    logic [FIELD_W-1:0] center_y_reg;
    logic [FIELD_W-1:0] center_z_reg;
    logic [TOL_W-1:0]   tolerance_reg;

    logic     q_push;
    drs_job_t q_push_job;
    logic     q_full;
    logic     q_pop;
    drs_job_t q_pop_job;
    logic     q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            tolerance_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CENTER_X:  center_x_reg  <= cfg_wr_data;
                REG_CENTER_Y:  center_y_reg  <= cfg_wr_data;
                REG_CENTER_Z:  center_z_reg  <= cfg_wr_data;
                REG_TOLERANCE: tolerance_reg <= cfg_wr_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    drs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_atom_x       (s_atom_x),
        .s_atom_y       (s_atom_y),
        .s_atom_z       (s_atom_z),
        .s_is_last      (s_is_last),
        .s_empty_marker (s_empty_marker),
        .center_x       (center_x_reg),
        .center_y       (center_y_reg),
        .center_z       (center_z_reg),
        .q_push         (q_push),
        .q_push_job     (q_push_job),
        .q_full         (q_full)
    );

    drs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    drs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tolerance (tolerance_reg),
        .q_empty   (q_empty),
        .q_pop_job (q_pop_job),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_score   (m_score)
    );

endmodule

// File: tb/sv/distance_restraint_score_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_restraint_score_test
// Streams ligand atom lists into the restraint scorer and checks each score
// against a cycle-free model of the flat-bottom penalty: running minimum of
// squared distance to the center, floor square root, squared excess over the
// tolerance, fixed penalty for empty lists. Directed corner lists come
// first, then random lists under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module distance_restraint_score_test;
    import drs_pkg::*;

    localparam int PHASE_ITEMS   = 212;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_MAX    = 10;

    localparam logic [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [SCORE_W-1:0] EMPTY_LIST_SCORE = SCORE_W'(99 * 65536);
    localparam logic [43:0] NEAREST_CLEAR = '1;

    class restraint_checker;
        longint signed      ctr_x;
        longint signed      ctr_y;
        longint signed      ctr_z;
        logic [TOL_W-1:0]   tol;
        logic [43:0]        nearest_sq;
        bit                 have_atom;
        logic [SCORE_W-1:0] score_queue[$];
        int                 errors;

        function new();
            ctr_x = 0;
            ctr_y = 0;
            ctr_z = 0;
            tol = '0;
            nearest_sq = NEAREST_CLEAR;
            have_atom = 1'b0;
            errors = 0;
        endfunction

        function longint signed coord_value(input logic [FIELD_W-1:0] v);
            logic signed [COORD_BITS-1:0] c;
            c = v[COORD_BITS-1:0];
            return longint'(c);
        endfunction

        function longint unsigned floor_root(input longint unsigned v);
            longint unsigned r;
            longint unsigned c;
            r = 0;
            for (int b = 22; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= v) r = c;
            end
            return r;
        endfunction

        function void set_reg(input logic [CFG_AW-1:0] idx, input logic [FIELD_W-1:0] data);
            case (idx)
                REG_CENTER_X: ctr_x = coord_value(data);
                REG_CENTER_Y: ctr_y = coord_value(data);
                REG_CENTER_Z: ctr_z = coord_value(data);
                REG_TOLERANCE: tol = data[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return score_queue.size();
        endfunction

        // fold one accepted request into the list state, queue its score if any
        function void take_atom(input logic [FIELD_W-1:0] x, y, z, input logic last, empty);
            longint signed   dx;
            longint signed   dy;
            longint signed   dz;
            logic [43:0]     d2;
            longint unsigned root;
            longint unsigned ex;
            logic [SCORE_W-1:0] score;
            if (empty) begin
                score_queue.insert(score_queue.size(), EMPTY_LIST_SCORE);
                nearest_sq = NEAREST_CLEAR;
                have_atom = 1'b0;
                return;
            end
            dx = coord_value(x) - ctr_x;
            dy = coord_value(y) - ctr_y;
            dz = coord_value(z) - ctr_z;
            d2 = 44'(dx * dx + dy * dy + dz * dz);
            if (d2 < nearest_sq) nearest_sq = d2;
            have_atom = 1'b1;
            if (!last) return;
            root = floor_root(longint'(nearest_sq));
            score = '0;
            if (root > longint'(tol)) begin
                ex = root - longint'(tol);
                score = SCORE_W'(ex * ex);
            end
            score_queue.insert(score_queue.size(), score);
            nearest_sq = NEAREST_CLEAR;
            have_atom = 1'b0;
        endfunction

        function void check_score(input logic [SCORE_W-1:0] got);
            logic [SCORE_W-1:0] want;
            if (score_queue.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) $display("score %0d with no request pending", got);
                return;
            end
            want = score_queue.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("score mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [FIELD_W-1:0] s_atom_x;
    logic [FIELD_W-1:0] s_atom_y;
    logic [FIELD_W-1:0] s_atom_z;
    logic               s_is_last;
    logic               s_empty_marker;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [SCORE_W-1:0] m_score;
    logic               cfg_wr_en;
    logic [CFG_AW-1:0]  cfg_addr;
    logic [FIELD_W-1:0] cfg_wr_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles;

    restraint_checker rb = new();

    distance_restraint_score uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_atom_x      (s_atom_x),
        .s_atom_y      (s_atom_y),
        .s_atom_z      (s_atom_z),
        .s_is_last     (s_is_last),
        .s_empty_marker(s_empty_marker),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_score       (m_score),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) rb.check_score(m_score);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_atom(input logic [FIELD_W-1:0] x, y, z, input logic last, empty);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_atom_x <= x;
        s_atom_y <= y;
        s_atom_z <= z;
        s_is_last <= last;
        s_empty_marker <= empty;
        do @(posedge aclk); while (!s_ready);
        rb.take_atom(x, y, z, last, empty);
    endtask

    // hold off requests until every score is back, then let the back end go quiet
    task automatic drain(input int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rb.pending() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [FIELD_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        rb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [FIELD_W-1:0] cx, cy, cz, tv);
        drain(SETTLE_CYCLES);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_TOLERANCE, tv);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] pick_coord(input longint signed c, input int reach,
                                                      input int mode);
        if (mode < 55) return FIELD_W'(c + longint'($urandom_range(2 * reach)) - longint'(reach));
        if (mode < 70) return $urandom_range(1) ? COORD_MAX : COORD_MIN;
        return FIELD_W'($urandom);
    endfunction

    initial begin
        int   sent;
        int   kind;
        int   len;
        int   mode;
        int   reach;
        bit   paused;
        logic [FIELD_W-1:0] ax;
        logic [FIELD_W-1:0] ay;
        logic [FIELD_W-1:0] az;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_atom_x <= '0;
        s_atom_y <= '0;
        s_atom_z <= '0;
        s_is_last <= 1'b0;
        s_empty_marker <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= REG_CENTER_X;
        cfg_wr_data <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset registers: center at origin, zero tolerance
        send_atom(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), 1'b1, 1'b1);
        send_atom('0, '0, '0, 1'b1, 1'b0);
        send_atom(20'h00001, '0, '0, 1'b1, 1'b0);
        send_atom(20'h00001, 20'h00001, '0, 1'b1, 1'b0);

        // farthest corner from the largest center
        configure(COORD_MAX, COORD_MAX, COORD_MAX, '0);
        send_atom(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_atom('0, '0, '0, 1'b0, 1'b0);
        send_atom(FIELD_W'(COORD_MAX - 3), COORD_MAX, FIELD_W'(COORD_MAX - 7), 1'b0, 1'b0);
        send_atom(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), 1'b1, 1'b0);
        send_atom(COORD_MAX, COORD_MAX, FIELD_W'(COORD_MAX - 1), 1'b0, 1'b0);
        send_atom('0, COORD_MIN, '0, 1'b0, 1'b0);
        send_atom(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), 1'b1, 1'b1);
        send_atom(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);

        // widest tolerance, upper data bits set on the write
        configure(COORD_MIN, COORD_MIN, COORD_MIN, 20'hFFFFF);
        send_atom(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
        send_atom(FIELD_W'(COORD_MIN + 100), COORD_MIN, COORD_MIN, 1'b1, 1'b0);

        // distance exactly at and just past the tolerance
        configure(COORD_MIN, COORD_MIN, COORD_MIN, 20'h00100);
        send_atom(FIELD_W'(COORD_MIN + 256), COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_atom(FIELD_W'(COORD_MIN + 257), COORD_MIN, COORD_MIN, 1'b1, 1'b0);

        // move the center while a list is open
        send_atom(FIELD_W'(COORD_MIN + 1000), COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        configure('0, COORD_MIN, COORD_MIN, 20'h00100);
        send_atom(20'h40000, COORD_MIN, COORD_MIN, 1'b1, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    configure(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                              FIELD_W'($urandom_range(16'hFFFF)));
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    configure(COORD_MIN, COORD_MIN, COORD_MIN, 20'h0FFFF);
                    send_idle_pct = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    configure(COORD_MAX, COORD_MAX, COORD_MAX, '0);
                    send_idle_pct = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    configure(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                              FIELD_W'($urandom));
                    send_idle_pct = 27;
                    recv_stall_pct = 27;
                end
            endcase
            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                if (ph == 1 && !paused && sent >= PHASE_ITEMS / 2) begin
                    drain(0);
                    paused = 1'b1;
                end
                kind = $urandom_range(99);
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
                if (kind < 6) begin
                    send_atom(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                              1'($urandom_range(1)), 1'b1);
                    sent++;
                end else begin
                    for (int k = 0; k < len; k++) begin
                        mode = $urandom_range(99);
                        reach = int'(rb.tol) + 300;
                        ax = pick_coord(rb.ctr_x, reach, mode);
                        ay = pick_coord(rb.ctr_y, reach, mode);
                        az = pick_coord(rb.ctr_z, reach, mode);
                        send_atom(ax, ay, az, (kind >= 12) && (k == len - 1), 1'b0);
                        sent++;
                    end
                    // cut the list short with an empty marker
                    if (kind < 12) begin
                        send_atom(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                                  1'($urandom_range(1)), 1'b1);
                        sent++;
                    end
                end
            end
        end

        drain(SETTLE_CYCLES);
        if (rb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
